// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the line wrapper.
// In simulation they expand to concurrent assertions.
// When SYNTHESIS is defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The expression must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
		else $error("assertion failed");
// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/gtlw_pkg.sv -----
// ----------------------------------------------------------------------------
// gtlw_pkg
// Types, constants and helpers shared by the greedy text line wrapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gtlw_pkg;

	// Code points with a special meaning.
	localparam logic [20:0] CP_END        = 21'h000000;
	localparam logic [20:0] CP_NEWLINE    = 21'h00000A;
	localparam logic [20:0] CP_SPACE      = 21'h000020;
	localparam logic [20:0] CP_IDEO_COMMA = 21'h003001;
	localparam logic [20:0] CP_IDEO_STOP  = 21'h003002;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		CFG_COLUMN_LIMIT    = 2'd0,
		CFG_ROW_LIMIT       = 2'd1,
		CFG_MULTILINE_ENABLE = 2'd2
	} cfg_index_t;

	// Reset values of the registers.
	localparam logic [7:0] RST_COLUMN_LIMIT    = 8'd16;
	localparam logic [7:0] RST_ROW_LIMIT       = 8'd4;
	localparam logic       RST_MULTILINE_ENABLE = 1'b1;

	// Default bound on the number of lines.
	localparam int DEF_MAX_LINES = 8;

	typedef struct packed {
		logic [7:0] column_limit;
		logic [7:0] row_limit;
		logic       multiline_enable;
	} wrap_cfg_t;

	// Running state of the wrapper, apart from the row number.
	typedef struct packed {
		logic [8:0] pending_count;
		logic [8:0] break_position;
		logic       break_valid;
		logic       drop_space;
		logic [7:0] longest_so_far;
		logic       overflow;
		logic       halted;
		logic       row_has_text;
	} wrap_state_t;

	// One result beat, with a flag saying whether the step produced one.
	typedef struct packed {
		logic       present;
		logic       line_valid;
		logic [2:0] line_index;
		logic [7:0] line_length;
		logic       string_end;
		logic [3:0] line_total;
		logic [7:0] longest_line;
		logic       overflowed;
	} wrap_result_t;

	// Saturates a nine-bit length to eight bits.
	function automatic logic [7:0] sat8(input logic [8:0] v);
		return v[8] ? 8'hFF : v[7:0];
	endfunction

endpackage

// ----- rtl/greedy_text_line_wrapper.sv -----
// ----------------------------------------------------------------------------
// greedy_text_line_wrapper
// Greedy word wrap of a code point stream into a box of rows and columns.
// ----------------------------------------------------------------------------
// Usage:
//   Code points enter on in_valid / in_stall with code_point as the payload;
//   a beat is taken at a rising edge with in_valid high and in_stall low.
//   Results leave on out_valid / out_stall in the same way. A text character
//   gives a result only when it completes a line; a newline gives one while
//   the box has room; code point 0 gives the end-of-string summary and clears
//   the running state. A beat is held in the input register and its result
//   is written to the output register. The block takes one code point per
//   cycle while the receiver does not stall, with the combinational step
//   logic between the input and output registers. When the receiver stalls,
//   the result is held and the input register keeps its beat; in_stall rises
//   only while the input register is full and its result cannot be written.
//   Configuration writes on cfg_wr_en / cfg_index / cfg_data take effect on
//   the next edge; an index beyond the list is ignored. Reset clears the
//   wrapping state and loads 16 columns, 4 rows and multiline mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module greedy_text_line_wrapper
	import gtlw_pkg::*;
#(
	parameter int MAX_LINES = DEF_MAX_LINES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [20:0] code_point,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        line_valid,
	output logic [2:0]  line_index,
	output logic [7:0]  line_length,
	output logic        string_end,
	output logic [3:0]  line_total,
	output logic [7:0]  longest_line,
	output logic        overflowed
);

	localparam int ROW_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

	wrap_cfg_t        cfg_q;
	wrap_state_t      state_q;
	wrap_state_t      state_n;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] row_n;
	wrap_result_t     res;
	wrap_result_t     out_q;
	logic             valid_s1;
	logic [20:0]      code_s1;
	logic             out_valid_q;
	logic             advance;
	logic             accept;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.column_limit     <= RST_COLUMN_LIMIT;
			cfg_q.row_limit        <= RST_ROW_LIMIT;
			cfg_q.multiline_enable <= RST_MULTILINE_ENABLE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_COLUMN_LIMIT:     cfg_q.column_limit     <= cfg_data;
				CFG_ROW_LIMIT:        cfg_q.row_limit        <= cfg_data;
				CFG_MULTILINE_ENABLE: cfg_q.multiline_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the input beat is processed once the output register is free.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1 <= code_point;
		end
	end

	// Step logic for the code point in the input register.
	gtlw_step #(
		.MAX_LINES (MAX_LINES)
	) u_step (
		.cfg        (cfg_q),
		.state      (state_q),
		.row        (row_q),
		.code_point (code_s1),
		.state_n    (state_n),
		.row_n      (row_n),
		.res        (res)
	);

	// Wrapping state, updated as each beat is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			row_q   <= '0;
		end else if (advance) begin
			state_q <= state_n;
			row_q   <= row_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.present) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.present) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign line_valid   = out_q.line_valid;
	assign line_index   = out_q.line_index;
	assign line_length  = out_q.line_length;
	assign string_end   = out_q.string_end;
	assign line_total   = out_q.line_total;
	assign longest_line = out_q.longest_line;
	assign overflowed   = out_q.overflowed;

	// Checks on the wrapper's own logic.
	`ASSERT_ALWAYS(a_result_kind, clk, arst_n, !out_valid_q || out_q.string_end || out_q.line_valid)
	`ASSERT_ALWAYS(a_halt_sets_overflow, clk, arst_n, !state_q.halted || state_q.overflow)
	`ASSERT_NEXT(a_end_clears, clk, arst_n, advance && code_s1 == CP_END, state_q == '0 && row_q == '0)
	`ASSERT_NEXT(a_end_reported, clk, arst_n, advance && code_s1 == CP_END, out_valid_q && out_q.string_end)

endmodule

// ----- rtl/gtlw_step.sv -----
// ----------------------------------------------------------------------------
// gtlw_step
// Next-state and result logic for one code point of the line wrapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtlw_step
	import gtlw_pkg::*;
#(
	parameter int MAX_LINES = DEF_MAX_LINES,
	localparam int ROW_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
	input  wrap_cfg_t          cfg,
	input  wrap_state_t        state,
	input  logic [ROW_W-1:0]   row,
	input  logic [20:0]        code_point,
	output wrap_state_t        state_n,
	output logic [ROW_W-1:0]   row_n,
	output wrap_result_t       res
);

	logic [7:0] rows;
	logic       zero_box;
	logic [8:0] row_ext;
	logic [8:0] row_inc;
	logic       last_row;
	logic       last_box_row;
	logic       is_break;
	logic [8:0] cnt;
	logic [8:0] bp;
	logic [8:0] len9;
	logic [7:0] len;
	logic       rht;

	// Limits seen by this step. The line store bound only stops the next row
	// from opening; the choice between a wrap and a cut follows the box alone.
	assign rows         = cfg.multiline_enable ? cfg.row_limit : 8'd1;
	assign zero_box     = (cfg.column_limit == 8'd0) || (cfg.row_limit == 8'd0);
	assign row_ext      = 9'(row);
	assign row_inc      = row_ext + 9'd1;
	assign last_box_row = row_inc >= {1'b0, rows};
	assign last_row     = (row_inc >= 9'(MAX_LINES)) || last_box_row;
	assign is_break = (code_point == CP_SPACE) || (code_point == CP_IDEO_COMMA)
		|| (code_point == CP_IDEO_STOP);

	always_comb begin
		state_n = state;
		row_n   = row;
		res     = '0;
		cnt     = state.pending_count + 9'd1;
		bp      = state.break_position;
		len9    = '0;
		len     = '0;
		rht     = state.row_has_text;

		if (code_point == CP_END) begin
			// End of string: close the last line and report the summary.
			if (!state.halted && !zero_box) begin
				len = sat8(state.pending_count);
				rht = (len != 8'd0);
				if (len > state_n.longest_so_far) begin
					state_n.longest_so_far = len;
				end
				if (!(row_ext == 9'd0 && !rht)) begin
					res.line_valid  = 1'b1;
					res.line_index  = row_ext[2:0];
					res.line_length = len;
				end
			end
			res.present      = 1'b1;
			res.string_end   = 1'b1;
			res.line_total   = (row_ext == 9'd0 && !rht) ? 4'd0 : row_inc[3:0];
			res.longest_line = state_n.longest_so_far;
			res.overflowed   = state.overflow;
			state_n          = '0;
			row_n            = '0;
		end else if (state.halted) begin
			// Text after the box filled up is ignored.
		end else if (zero_box) begin
			state_n.overflow = 1'b1;
			state_n.halted   = 1'b1;
		end else begin
			if (code_point == CP_NEWLINE) begin
				// A newline closes the line as it stands.
				len                   = sat8(state.pending_count);
				state_n.pending_count = '0;
			end else begin
				// Text character, possibly a break point.
				if (is_break) begin
					bp                  = cnt;
					state_n.break_valid = 1'b1;
					state_n.drop_space  = (code_point == CP_SPACE);
				end
				state_n.pending_count = cnt;
				if (cnt > {1'b0, cfg.column_limit}) begin
					// The line is full: wrap at the break or cut at the limit.
					if (!state_n.break_valid || last_box_row) begin
						bp                 = {1'b0, cfg.column_limit};
						state_n.overflow   = 1'b1;
						state_n.drop_space = 1'b0;
					end
					if (bp > cnt) begin
						bp = cnt;
					end
					state_n.pending_count = cnt - bp;
					len9 = bp - ((state_n.drop_space && bp != 9'd0) ? 9'd1 : 9'd0);
					len  = sat8(len9);
				end
				state_n.break_position = bp;
			end

			// A completed line is reported and, unless it was the last row, the next row opened.
			if (code_point == CP_NEWLINE || cnt > {1'b0, cfg.column_limit}) begin
				state_n.row_has_text = (len != 8'd0);
				if (len > state_n.longest_so_far) begin
					state_n.longest_so_far = len;
				end
				res.present         = 1'b1;
				res.line_valid      = 1'b1;
				res.line_index      = row_ext[2:0];
				res.line_length     = len;
				state_n.break_valid = 1'b0;
				if (last_row) begin
					state_n.overflow = 1'b1;
					state_n.halted   = 1'b1;
				end else begin
					row_n                = ROW_W'(row_inc);
					state_n.row_has_text = 1'b0;
					state_n.drop_space   = 1'b0;
				end
			end
		end
	end

endmodule
